>>> hdl/qte_pkg.sv
// ============================================================================
// qte_pkg - shared types and constants for quaternion to Euler conversion
// Widths, CORDIC arctangent table, rounding helper and singularity codes.
// ============================================================================
`default_nettype none

package qte_pkg;

    localparam int QW        = 16;                  // quaternion component width
    localparam int PW        = 32;                  // product width
    localparam int OPW       = 36;                  // atan2 operand width
    localparam int TW        = 32;                  // arcsine operand, Q30 signed
    localparam int NW        = 62;                  // square root radicand width
    localparam int RW        = 31;                  // square root result width
    localparam int CW        = 44;                  // CORDIC datapath width
    localparam int ANGW      = 28;                  // angle, degrees * 65536
    localparam int SQ_STAGES = 31;                  // one root bit per stage
    localparam int NORM_MSB  = 38;                  // normalised magnitude floor
    localparam int KW        = 6;                   // normalise shift width
    localparam int MAX_STEPS = 32;

    localparam int FRAC_BITS = 14;
    localparam int ONE2      = 1 << (2 * FRAC_BITS);
    localparam int HALF2     = 1 << (2 * FRAC_BITS - 1);
    localparam int YAW_SHIFT = 31 - 2 * FRAC_BITS;  // 2*xyzw taken to Q30
    localparam int ANG_90    = 90 * 65536;
    localparam int ROUND_ADD = 256;
    localparam int OUT_SHIFT = 9;
    localparam int YAW_MAX   = 90 * 128;

    localparam logic [NW-1:0] SQ_ONE = NW'(1) << 60;

    // atan(2^-i) in degrees * 65536
    localparam int ATAN_TAB [MAX_STEPS] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0,
        0, 0, 0, 0, 0, 0, 0, 0
    };

    typedef enum logic [1:0] {
        SING_NONE = 2'd0,
        SING_POS  = 2'd1,
        SING_NEG  = 2'd2
    } t_sing;

    typedef logic signed [OPW-1:0] t_opnd;

    typedef struct packed {
        t_opnd                roll_y;
        t_opnd                roll_x;
        t_opnd                pitch_y;
        t_opnd                pitch_x;
        logic signed [TW-1:0] yaw_t;
        t_sing                code;
    } t_ops;

    // round half up to 1/128 degree
    function automatic logic signed [ANGW:0] to_deg128(input logic signed [ANGW:0] a);
        return (a + (ANGW + 1)'(ROUND_ADD)) >>> OUT_SHIFT;
    endfunction

endpackage

`default_nettype wire

>>> hdl/qte_prep.sv
// ============================================================================
// qte_prep - products, sums and arcsine radicand
// Four stages: products, atan2 operands and singularity test, square, radicand.
// ============================================================================
`default_nettype none

module qte_prep (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_en,
    input  wire                                i_valid,
    input  wire logic signed [qte_pkg::QW-1:0] i_x,
    input  wire logic signed [qte_pkg::QW-1:0] i_y,
    input  wire logic signed [qte_pkg::QW-1:0] i_z,
    input  wire logic signed [qte_pkg::QW-1:0] i_w,
    output logic                               o_valid,
    output qte_pkg::t_ops                      o_ops,
    output logic [qte_pkg::NW-1:0]             o_n
);

    logic                              r_v1, r_v2, r_v3, r_v4;
    logic signed [qte_pkg::PW-1:0]     r_xw, r_yz, r_xx, r_zz, r_yw, r_xz, r_yy, r_xy, r_zw;
    logic signed [qte_pkg::QW-1:0]     r_x1, r_w1;
    qte_pkg::t_ops                     n_ops, r_ops2, r_ops3, r_ops4;
    logic signed [qte_pkg::PW:0]       n_xyzw;
    logic [qte_pkg::RW-1:0]            n_mag;
    logic [qte_pkg::NW-1:0]            n_sq, r_sq, r_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_comb begin
        n_xyzw         = (qte_pkg::PW + 1)'(r_xy) + (qte_pkg::PW + 1)'(r_zw);
        n_ops.roll_y   = (qte_pkg::t_opnd'(r_xw) - qte_pkg::t_opnd'(r_yz)) <<< 1;
        n_ops.roll_x   = qte_pkg::t_opnd'(qte_pkg::ONE2) - (qte_pkg::t_opnd'(r_xx) <<< 1)
                         - (qte_pkg::t_opnd'(r_zz) <<< 1);
        n_ops.pitch_y  = (qte_pkg::t_opnd'(r_yw) - qte_pkg::t_opnd'(r_xz)) <<< 1;
        n_ops.pitch_x  = qte_pkg::t_opnd'(qte_pkg::ONE2) - (qte_pkg::t_opnd'(r_yy) <<< 1)
                         - (qte_pkg::t_opnd'(r_zz) <<< 1);
        n_ops.code     = qte_pkg::SING_NONE;
        if (n_xyzw == (qte_pkg::PW + 1)'(qte_pkg::HALF2)) begin
            n_ops.code = qte_pkg::SING_POS;
        end else if (n_xyzw == -(qte_pkg::PW + 1)'(qte_pkg::HALF2)) begin
            n_ops.code = qte_pkg::SING_NEG;
        end
        if (n_ops.code != qte_pkg::SING_NONE) begin
            n_ops.roll_y = qte_pkg::t_opnd'(r_x1);
            n_ops.roll_x = qte_pkg::t_opnd'(r_w1);
        end
        // clamp to +-1, then Q30
        if (n_xyzw > (qte_pkg::PW + 1)'(qte_pkg::HALF2)) begin
            n_ops.yaw_t = qte_pkg::TW'(1) <<< 30;
        end else if (n_xyzw < -(qte_pkg::PW + 1)'(qte_pkg::HALF2)) begin
            n_ops.yaw_t = -(qte_pkg::TW'(1) <<< 30);
        end else begin
            n_ops.yaw_t = qte_pkg::TW'(n_xyzw) <<< qte_pkg::YAW_SHIFT;
        end
        n_mag = r_ops2.yaw_t[qte_pkg::TW-1] ? qte_pkg::RW'(-r_ops2.yaw_t)
                                            : qte_pkg::RW'(r_ops2.yaw_t);
        n_sq  = n_mag * n_mag;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xw   <= i_x * i_w;
            r_yz   <= i_y * i_z;
            r_xx   <= i_x * i_x;
            r_zz   <= i_z * i_z;
            r_yw   <= i_y * i_w;
            r_xz   <= i_x * i_z;
            r_yy   <= i_y * i_y;
            r_xy   <= i_x * i_y;
            r_zw   <= i_z * i_w;
            r_x1   <= i_x;
            r_w1   <= i_w;
            r_ops2 <= n_ops;
            r_ops3 <= r_ops2;
            r_sq   <= n_sq;
            r_ops4 <= r_ops3;
            r_n    <= qte_pkg::SQ_ONE - r_sq;
        end
    end

    assign o_valid = r_v4;
    assign o_ops   = r_ops4;
    assign o_n     = r_n;

endmodule

`default_nettype wire

>>> hdl/qte_isqrt.sv
// ============================================================================
// qte_isqrt - pipelined integer square root
// Floor square root of a radicand up to 2^60, one result bit per stage.
// ============================================================================
`default_nettype none

module qte_isqrt #(
    parameter int SIDE_W = 8
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_en,
    input  wire                         i_valid,
    input  wire [qte_pkg::NW-1:0]       i_n,
    input  wire [SIDE_W-1:0]            i_side,
    output logic                        o_valid,
    output logic [qte_pkg::RW-1:0]      o_root,
    output logic [SIDE_W-1:0]           o_side
);

    localparam int STG = qte_pkg::SQ_STAGES;

    logic [qte_pkg::NW-1:0] r_num [STG];
    logic [qte_pkg::NW-1:0] r_res [STG];
    logic [qte_pkg::NW-1:0] n_num [STG];
    logic [qte_pkg::NW-1:0] n_res [STG];
    logic [qte_pkg::NW-1:0] w_nin [STG];
    logic [qte_pkg::NW-1:0] w_rin [STG];
    logic [qte_pkg::NW-1:0] w_bit [STG];
    logic [qte_pkg::NW-1:0] w_try [STG];
    logic [SIDE_W-1:0]      r_side [STG];
    logic                   r_vld [STG];

    always_comb begin
        for (int j = 0; j < STG; j++) begin
            w_nin[j] = (j == 0) ? i_n : r_num[(j == 0) ? 0 : j - 1];
            w_rin[j] = (j == 0) ? '0  : r_res[(j == 0) ? 0 : j - 1];
            w_bit[j] = qte_pkg::NW'(1) << (2 * (STG - 1 - j));
            w_try[j] = w_rin[j] + w_bit[j];
            if (w_nin[j] >= w_try[j]) begin
                n_num[j] = w_nin[j] - w_try[j];
                n_res[j] = (w_rin[j] >> 1) + w_bit[j];
            end else begin
                n_num[j] = w_nin[j];
                n_res[j] = w_rin[j] >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < STG; j++) begin
                r_vld[j] <= 1'b0;
            end
        end else if (i_en) begin
            for (int j = 0; j < STG; j++) begin
                r_vld[j] <= (j == 0) ? i_valid : r_vld[(j == 0) ? 0 : j - 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < STG; j++) begin
                r_num[j]  <= n_num[j];
                r_res[j]  <= n_res[j];
                r_side[j] <= (j == 0) ? i_side : r_side[(j == 0) ? 0 : j - 1];
            end
        end
    end

    assign o_valid = r_vld[STG-1];
    assign o_root  = r_res[STG-1][qte_pkg::RW-1:0];
    assign o_side  = r_side[STG-1];

endmodule

`default_nettype wire

>>> hdl/qte_cordic.sv
// ============================================================================
// qte_cordic - pipelined full-quadrant vectoring CORDIC atan2
// Normalise, quadrant pre-rotation, then one micro-rotation per stage.
// ============================================================================
`default_nettype none

module qte_cordic #(
    parameter int STEPS = 16
) (
    input  wire                                  i_clk,
    input  wire                                  i_en,
    input  wire qte_pkg::t_opnd                  i_y,
    input  wire qte_pkg::t_opnd                  i_x,
    output logic signed [qte_pkg::ANGW-1:0]      o_ang
);

    localparam int CW   = qte_pkg::CW;
    localparam int ANGW = qte_pkg::ANGW;
    localparam int OPW  = qte_pkg::OPW;

    logic [OPW-1:0]          n_ax, n_ay, n_mag;
    logic [qte_pkg::KW-1:0]  n_p, r_k;
    logic                    r_zero1;
    qte_pkg::t_opnd          r_x1, r_y1;
    logic signed [CW-1:0]    n_xs, n_ys;

    logic signed [CW-1:0]    r_sx [STEPS+1];
    logic signed [CW-1:0]    r_sy [STEPS+1];
    logic signed [ANGW-1:0]  r_sa [STEPS+1];
    logic                    r_sz [STEPS+1];
    logic signed [CW-1:0]    n_sx [STEPS+1];
    logic signed [CW-1:0]    n_sy [STEPS+1];
    logic signed [ANGW-1:0]  n_sa [STEPS+1];

    always_comb begin
        n_ax  = i_x[OPW-1] ? OPW'(-i_x) : OPW'(i_x);
        n_ay  = i_y[OPW-1] ? OPW'(-i_y) : OPW'(i_y);
        n_mag = n_ax | n_ay;
        n_p   = '0;
        for (int b = 0; b < OPW; b++) begin
            if (n_mag[b]) begin
                n_p = qte_pkg::KW'(b);
            end
        end
    end

    always_comb begin
        n_xs = CW'(r_x1) <<< r_k;
        n_ys = CW'(r_y1) <<< r_k;
        n_sx[0] = n_xs;
        n_sy[0] = n_ys;
        n_sa[0] = '0;
        if (n_xs < 0) begin
            if (n_ys >= 0) begin
                n_sx[0] = n_ys;
                n_sy[0] = -n_xs;
                n_sa[0] = ANGW'(qte_pkg::ANG_90);
            end else begin
                n_sx[0] = -n_ys;
                n_sy[0] = n_xs;
                n_sa[0] = -ANGW'(qte_pkg::ANG_90);
            end
        end
        for (int j = 0; j < STEPS; j++) begin
            if (r_sy[j] > 0) begin
                n_sx[j+1] = r_sx[j] + (r_sy[j] >>> j);
                n_sy[j+1] = r_sy[j] - (r_sx[j] >>> j);
                n_sa[j+1] = r_sa[j] + ANGW'(qte_pkg::ATAN_TAB[j]);
            end else begin
                n_sx[j+1] = r_sx[j] - (r_sy[j] >>> j);
                n_sy[j+1] = r_sy[j] + (r_sx[j] >>> j);
                n_sa[j+1] = r_sa[j] - ANGW'(qte_pkg::ATAN_TAB[j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x1    <= i_x;
            r_y1    <= i_y;
            r_k     <= qte_pkg::KW'(qte_pkg::NORM_MSB) - n_p;
            r_zero1 <= (n_mag == '0);
            r_sz[0] <= r_zero1;
            for (int j = 0; j <= STEPS; j++) begin
                r_sx[j] <= n_sx[j];
                r_sy[j] <= n_sy[j];
                r_sa[j] <= n_sa[j];
            end
            for (int j = 0; j < STEPS; j++) begin
                r_sz[j+1] <= r_sz[j];
            end
        end
    end

    assign o_ang = r_sz[STEPS] ? '0 : r_sa[STEPS];

endmodule

`default_nettype wire

>>> hdl/quaternion_to_euler_degrees.sv
// ============================================================================
// quaternion_to_euler_degrees - quaternion to roll, pitch, yaw in 1/128 degree
// Pipeline: prep, square root, CORDIC atan2, output register.
// Throughput: one transaction per cycle, set by the fully unrolled pipeline,
// while the skid entry is empty; a full skid entry stalls the pipeline.
// A two-entry output register and skid stage keep input and output apart.
// Reset clears valid bits only; no clearing pass, no state kept between items.
// ============================================================================
`default_nettype none

module quaternion_to_euler_degrees #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [63:0] i_s_tdata,   // quat_x, quat_y, quat_z, quat_w
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [47:0] o_m_tdata,   // roll_deg, pitch_deg, yaw_deg
    output logic [1:0]  o_m_tuser    // singular_code
);

    localparam int CORD_LAT = CORDIC_STEPS + 2;
    localparam int SIDE_W   = $bits(qte_pkg::t_ops);
    localparam int ANGW     = qte_pkg::ANGW;

    typedef struct packed {
        qte_pkg::t_sing     code;
        logic signed [14:0] yaw;
        logic signed [15:0] pitch;
        logic signed [16:0] roll;
    } t_res;

    logic                        w_en;
    logic                        w_pv;
    qte_pkg::t_ops               w_pops;
    logic [qte_pkg::NW-1:0]      w_pn;
    logic                        w_qv;
    logic [qte_pkg::RW-1:0]      w_root;
    logic [SIDE_W-1:0]           w_side;
    qte_pkg::t_ops               w_ops;
    logic signed [ANGW-1:0]      w_rang, w_pang, w_yang;
    logic signed [ANGW:0]        w_ra, w_rdeg, w_pdeg, w_ydeg;

    logic                        r_cv [CORD_LAT];
    qte_pkg::t_sing              r_cc [CORD_LAT];
    t_res                        n_res, r_out, r_skid;
    logic                        r_out_v, r_skid_v;

    assign w_en       = !r_skid_v;
    assign o_s_tready = w_en;

    qte_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_tvalid),
        .i_x     (i_s_tdata[15:0]),
        .i_y     (i_s_tdata[31:16]),
        .i_z     (i_s_tdata[47:32]),
        .i_w     (i_s_tdata[63:48]),
        .o_valid (w_pv),
        .o_ops   (w_pops),
        .o_n     (w_pn)
    );

    qte_isqrt #(
        .SIDE_W (SIDE_W)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_pv),
        .i_n     (w_pn),
        .i_side  (w_pops),
        .o_valid (w_qv),
        .o_root  (w_root),
        .o_side  (w_side)
    );

    assign w_ops = qte_pkg::t_ops'(w_side);

    qte_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_y   (w_ops.roll_y),
        .i_x   (w_ops.roll_x),
        .o_ang (w_rang)
    );

    qte_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_y   (w_ops.pitch_y),
        .i_x   (w_ops.pitch_x),
        .o_ang (w_pang)
    );

    qte_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_y   (qte_pkg::t_opnd'(w_ops.yaw_t)),
        .i_x   (qte_pkg::t_opnd'({1'b0, w_root})),
        .o_ang (w_yang)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < CORD_LAT; j++) begin
                r_cv[j] <= 1'b0;
            end
        end else if (w_en) begin
            for (int j = 0; j < CORD_LAT; j++) begin
                r_cv[j] <= (j == 0) ? w_qv : r_cv[(j == 0) ? 0 : j - 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < CORD_LAT; j++) begin
                r_cc[j] <= (j == 0) ? w_ops.code : r_cc[(j == 0) ? 0 : j - 1];
            end
        end
    end

    always_comb begin
        unique case (r_cc[CORD_LAT-1])
            qte_pkg::SING_POS: w_ra = (ANGW + 1)'(w_rang) <<< 1;
            qte_pkg::SING_NEG: w_ra = -((ANGW + 1)'(w_rang) <<< 1);
            default:           w_ra = (ANGW + 1)'(w_rang);
        endcase
        w_rdeg      = qte_pkg::to_deg128(w_ra);
        w_pdeg      = qte_pkg::to_deg128((ANGW + 1)'(w_pang));
        w_ydeg      = qte_pkg::to_deg128((ANGW + 1)'(w_yang));
        n_res.code  = r_cc[CORD_LAT-1];
        n_res.roll  = w_rdeg[16:0];
        n_res.pitch = (r_cc[CORD_LAT-1] != qte_pkg::SING_NONE) ? '0 : w_pdeg[15:0];
        n_res.yaw   = w_ydeg[14:0];
    end

    // output register plus skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_skid_v) begin
            if (r_out_v && !i_m_tready) begin
                r_skid_v <= r_cv[CORD_LAT-1];
            end else begin
                r_out_v <= r_cv[CORD_LAT-1];
            end
        end else if (i_m_tready) begin
            r_skid_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_v) begin
            if (r_out_v && !i_m_tready) begin
                r_skid <= n_res;
            end else begin
                r_out <= n_res;
            end
        end else if (i_m_tready) begin
            r_out <= r_skid;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = {r_out.yaw, r_out.pitch, r_out.roll};
    assign o_m_tuser  = r_out.code;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry held without output entry");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_out_v && !i_m_tready))
        else $error("skid entry filled while output was free");

    a_pitch_singular: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser != qte_pkg::SING_NONE)) |-> (o_m_tdata[32:17] == '0))
        else $error("pitch not zero at singular point");

    a_code_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser == qte_pkg::SING_NONE || o_m_tuser == qte_pkg::SING_POS
                        || o_m_tuser == qte_pkg::SING_NEG))
        else $error("singular code out of range");

    a_yaw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ($signed(o_m_tdata[47:33]) <= 15'(qte_pkg::YAW_MAX)
                        && $signed(o_m_tdata[47:33]) >= -15'(qte_pkg::YAW_MAX)))
        else $error("yaw beyond 90 degrees");

endmodule

`default_nettype wire

>>> verif/tb_quaternion_to_euler_degrees.sv
// ============================================================================
// tb_quaternion_to_euler_degrees
// Streams directed and random quaternions through the converter and checks
// roll, pitch, yaw and the singularity flag against an in-bench predictor,
// across phases of sender idling and receiver back-pressure.
// ============================================================================
module tb_quaternion_to_euler_degrees;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RAND   = 1500;
    localparam int N_STEPS  = 16;
    localparam int WD_LIMIT = 4000;

    typedef struct {
        logic [16:0] roll;
        logic [15:0] pitch;
        logic [14:0] yaw;
        logic [1:0]  code;
    } t_euler;

    class euler_board;
        t_euler pending[$];
        int     errors;
        int     checked;

        function automatic longint iabs(longint v);
            return v < 0 ? -v : v;
        endfunction

        function automatic longint vec_atan2(longint yv, longint xv);
            longint ang, t, dx, dy;
            longint hi, lo;
            hi = longint'(1) << 40;
            lo = longint'(1) << 38;
            ang = 0;
            if (xv == 0 && yv == 0) return 0;
            while (iabs(xv) >= hi || iabs(yv) >= hi) begin
                xv = xv / 2;
                yv = yv / 2;
            end
            while (iabs(xv) < lo && iabs(yv) < lo) begin
                xv = xv * 2;
                yv = yv * 2;
            end
            if (xv < 0) begin
                t = xv;
                if (yv >= 0) begin
                    xv = yv; yv = -t; ang = qte_pkg::ANG_90;
                end else begin
                    xv = -yv; yv = t; ang = -qte_pkg::ANG_90;
                end
            end
            for (int i = 0; i < N_STEPS; i++) begin
                dx = yv >>> i;
                dy = xv >>> i;
                if (yv > 0) begin
                    xv += dx; yv -= dy; ang += qte_pkg::ATAN_TAB[i];
                end else begin
                    xv -= dx; yv += dy; ang -= qte_pkg::ATAN_TAB[i];
                end
            end
            return ang;
        endfunction

        function automatic longint unsigned root(longint unsigned n);
            longint unsigned res, b;
            res = 0;
            b = 64'd1 << 62;
            while (b > n) b >>= 2;
            while (b != 0) begin
                if (n >= res + b) begin
                    n -= res + b;
                    res = (res >> 1) + b;
                end else begin
                    res >>= 1;
                end
                b >>= 2;
            end
            return res;
        endfunction

        function automatic longint deg128(longint a);
            return (a + qte_pkg::ROUND_ADD) >>> qte_pkg::OUT_SHIFT;
        endfunction

        function void note(logic [63:0] d);
            longint x, y, z, w, one2, xyzw, s, t, r, p, yw;
            longint unsigned mag;
            t_euler e;
            x = longint'($signed(d[15:0]));
            y = longint'($signed(d[31:16]));
            z = longint'($signed(d[47:32]));
            w = longint'($signed(d[63:48]));
            one2 = qte_pkg::ONE2;
            xyzw = x * y + z * w;
            r = deg128(vec_atan2(2*x*w - 2*y*z, one2 - 2*x*x - 2*z*z));
            p = deg128(vec_atan2(2*y*w - 2*x*z, one2 - 2*y*y - 2*z*z));
            e.code = qte_pkg::SING_NONE;
            if (xyzw == qte_pkg::HALF2) begin
                e.code = qte_pkg::SING_POS;
                r = deg128(2 * vec_atan2(x, w));
                p = 0;
            end else if (xyzw == -qte_pkg::HALF2) begin
                e.code = qte_pkg::SING_NEG;
                r = deg128(-2 * vec_atan2(x, w));
                p = 0;
            end
            s = 2 * xyzw;
            if (s > one2) s = one2;
            if (s < -one2) s = -one2;
            t = s * 4;
            mag = longint'(iabs(t));
            yw = deg128(vec_atan2(t, longint'(root((64'd1 << 60) - mag * mag))));
            e.roll  = r[16:0];
            e.pitch = p[15:0];
            e.yaw   = yw[14:0];
            pending.push_back(e);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("mismatch %0d: %s got %0h expected %0h", checked, what, got, want);
        endtask

        task check(logic [47:0] d, logic [1:0] u);
            t_euler e;
            if (pending.size() == 0) begin
                report("unexpected transaction", {16'd0, d[47:32]}, 0);
                return;
            end
            e = pending.pop_front();
            if (d[16:0]  !== e.roll)  report("roll",  d[16:0],  e.roll);
            if (d[32:17] !== e.pitch) report("pitch", d[32:17], e.pitch);
            if (d[47:33] !== e.yaw)   report("yaw",   d[47:33], e.yaw);
            if (u        !== e.code)  report("code",  u,        e.code);
            checked++;
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic [63:0] i_s_tdata = '0;
    logic        i_m_tready = 1'b0;
    logic        o_s_tready, o_m_tvalid;
    logic [47:0] o_m_tdata;
    logic [1:0]  o_m_tuser;

    euler_board board = new();
    int  phase = 0;
    int  quiet = 0;
    int  n_in = 0;
    bit  sent_all = 0;

    quaternion_to_euler_degrees u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tuser(o_m_tuser)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            board.note(i_s_tdata);
            n_in++;
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) board.check(o_m_tdata, o_m_tuser);
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) quiet = 0;
        else quiet++;
        if (i_rst_n && quiet >= WD_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", WD_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        case (phase)
            2: i_m_tready <= ($urandom_range(99) >= 79);
            3: i_m_tready <= ($urandom_range(99) >= 15);
            default: i_m_tready <= 1'b1;
        endcase
    end

    function automatic logic [63:0] pack(int x, int y, int z, int w);
        return {w[15:0], z[15:0], y[15:0], x[15:0]};
    endfunction

    function automatic logic [63:0] rand_quat();
        int x, y, z, w;
        case ($urandom_range(9))
            0, 1, 2: return {$urandom, $urandom};
            3: begin
                // on the gimbal lock, with random sign
                x = $urandom_range(16384, 1);
                w = $urandom_range(16384);
                y = (1 << 27) / x;
                if (x * y == (1 << 27)) return $urandom_range(1) ?
                    pack(x, y, 0, w) : pack(x, -y, 0, w);
                return pack(8192, 8192, -8192 * 0 + 8192, 8192);
            end
            default: begin
                // random components, each within +-0.5
                x = $signed($urandom_range(32767)) - 16384;
                y = $signed($urandom_range(32767)) - 16384;
                z = $signed($urandom_range(32767)) - 16384;
                w = $signed($urandom_range(32767)) - 16384;
                return pack(x / 2, y / 2, z / 2, w / 2);
            end
        endcase
    endfunction

    task send(logic [63:0] d);
        bit idle;
        forever begin
            @(negedge i_clk);
            idle = (phase == 1) ? ($urandom_range(99) < 79) :
                   (phase == 3) ? ($urandom_range(99) < 15) : 1'b0;
            i_s_tvalid <= !idle;
            i_s_tdata  <= idle ? i_s_tdata : d;
            if (!idle) begin
                @(posedge i_clk);
                while (!o_s_tready) @(posedge i_clk);
                return;
            end
        end
    endtask

    task idle_until_empty();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);
    endtask

    logic [63:0] directed[$];

    initial begin
        directed = '{
            pack(0, 0, 0, 0), pack(0, 0, 0, 16384), pack(16384, 0, 0, 0),
            pack(16384, 0, 16384, 0), pack(0, 16384, 16384, 0),
            pack(8192, 8192, 8192, 8192), pack(8192, -8192, 8192, -8192),
            pack(16384, 8192, 0, 0), pack(-16384, 8192, 0, 4000),
            pack(32767, 32767, 32767, 32767), pack(-32768, -32768, -32768, -32768),
            pack(-32768, 32767, -32768, 32767), pack(32767, -32768, 0, 1),
            pack(0, 0, 0, -32768), pack(11585, 0, 0, 11585),
            pack(0, 11585, 0, 11585), pack(0, 0, 11585, 11585),
            pack(-1, -1, -1, -1), pack(1, 1, 1, 1)
        };
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed[k]) send(directed[k]);
        for (int k = 0; k < N_RAND; k++) begin
            phase = (k * 4) / N_RAND;
            if (k == N_RAND / 2) idle_until_empty();
            send(rand_quat());
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        sent_all = 1;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("%0d quaternions in, %0d results checked, over four idling phases",
                 n_in, board.checked);
        $display("directed cases: zero, extremes, gimbal lock, clamped arcsine, 180 deg");
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
